@@ src/tsp_pkg.sv @@
// Shared constants, codes and item types of the tone sequence player.
package tsp_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = IDX_W + 1;
    localparam int CLK_W       = 28;
    localparam int FREQ_W      = 16;
    localparam int DUR_W       = 16;
    localparam int MS_W        = 16;
    localparam int LEVEL_W     = CLK_W - 1;
    localparam int ENTRY_W     = FREQ_W + DUR_W;
    localparam int DIV_STEPS   = CLK_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [CLK_W-1:0] SYS_FREQ_RESET = CLK_W'(125000000);

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [IDX_W-1:0]  tone_index;
        logic [FREQ_W-1:0] tone_freq;
        logic [DUR_W-1:0]  tone_duration;
        logic              last_entry;
        logic [MS_W-1:0]   elapsed_ms;
    } tsp_cmd_t;

    typedef struct packed {
        logic               output_enabled;
        logic [CLK_W-1:0]   period_wrap;
        logic [LEVEL_W-1:0] duty_level;
        logic               playing;
        logic [IDX_W-1:0]   current_position;
    } tsp_res_t;

endpackage

@@ src/tsp_div.sv @@
// Bit-serial restoring divider: one quotient bit per clock cycle.
module tsp_div
    import tsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CLK_W-1:0]  dividend,
    input  logic [FREQ_W-1:0] divisor,
    output logic              done,
    output logic [CLK_W-1:0]  quotient
);

    logic [CLK_W-1:0]     quo_reg;
    logic [FREQ_W-1:0]    rem_reg;
    logic [FREQ_W-1:0]    dsr_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic                 run_reg;
    logic                 done_reg;

    logic [FREQ_W:0]      trial;
    logic [FREQ_W:0]      diff;
    logic                 fits;

    // The dividend shifts out of the top of the quotient register while the
    // quotient bits shift in at the bottom.
    assign trial = {rem_reg, quo_reg[CLK_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg   <= 1'b1;
                count_reg <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (run_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == DIV_CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[CLK_W-2:0], fits};
            rem_reg <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/tone_sequence_player.sv @@
// Top level of the tone sequence player: command decode, tone table and player state.
//
// The player takes one item at a time: an item is taken at a rising edge with
// start high and busy low, and its result appears on res for exactly one cycle
// with done high, which the receiver must take as it comes. A load item without
// its last flag, a stop item, an unused mode or a tick that starts no tone is
// answered from the idle state, with done registered as the item is taken.
// An item that starts a tone (a final load, or a tick that moves to the next
// tone) reads the table, then runs the serial divider for the system clock
// frequency over the tone frequency at one quotient bit per cycle. With a
// nonzero frequency the entry is read, the tone is set up and the divider
// loaded, the divider works out all 28 quotient bits and the wrap is registered
// before the result appears; the next item can be taken at the edge that ends
// the result cycle. With frequency zero the divider is skipped and the result
// is reported from the tone set-up state. Table slots come up undefined after
// reset and must be loaded before they are played. The clock frequency register
// may only be written while busy is low.
module tone_sequence_player
    import tsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tsp_cmd_t         cmd,
    output logic             done,
    output tsp_res_t         res,
    input  logic             cfg_wr_en,
    input  logic [CLK_W-1:0] cfg_wr_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_TONE, ST_DIV} state_t;

    state_t              state_reg;
    logic                done_reg;
    logic [LEN_W-1:0]    seq_len_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic [DUR_W-1:0]    remaining_reg;
    logic                enabled_reg;
    logic [CLK_W-1:0]    wrap_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [MS_W-1:0]     left_reg;
    logic [IDX_W-1:0]    rd_addr_reg;
    logic [CLK_W-1:0]    sys_freq_reg;

    // Tone table: frequency in the low half of an entry, duration in the high.
    logic [ENTRY_W-1:0]  table_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;

    logic                accept;
    logic [LEN_W-1:0]    next_pos;
    logic [FREQ_W-1:0]   tone_f;
    logic [DUR_W-1:0]    tone_d;
    logic [CLK_W-2:0]    half_clk;
    logic [FREQ_W-1:0]   clamp_f;
    logic [FREQ_W-1:0]   div_f;
    logic                div_start;
    logic                div_done;
    logic [CLK_W-1:0]    div_q;
    logic [CLK_W-1:0]    wrap_next;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign next_pos = {1'b0, pos_reg} + 1'b1;

    // Fields of the entry just read for the tone being started.
    assign tone_f   = rd_data_reg[FREQ_W-1:0];
    assign tone_d   = rd_data_reg[ENTRY_W-1:FREQ_W];

    // The frequency is clamped to half the clock; if that half is zero the
    // divider works with one instead.
    assign half_clk = sys_freq_reg[CLK_W-1:1];
    assign clamp_f  = ({{(CLK_W-1-FREQ_W){1'b0}}, tone_f} > half_clk)
                      ? half_clk[FREQ_W-1:0] : tone_f;
    assign div_f    = (clamp_f == '0) ? FREQ_W'(1) : clamp_f;

    assign div_start = (state_reg == ST_TONE) && (tone_f != '0);

    // The wrap is the quotient less one, held at zero for a zero quotient.
    assign wrap_next = (div_q == '0) ? '0 : div_q - 1'b1;

    tsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sys_freq_reg),
        .divisor  (div_f),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_freq_reg <= SYS_FREQ_RESET;
        end
        else if (cfg_wr_en)
        begin
            sys_freq_reg <= cfg_wr_data;
        end
    end

    // The table is written as the load item is taken, so a final load of slot
    // zero is seen by the read in the following cycle.
    always_ff @(posedge clk)
    begin
        if (accept && cmd.mode == MODE_LOAD)
        begin
            table_mem[cmd.tone_index] <= {cmd.tone_duration, cmd.tone_freq};
        end
        rd_data_reg <= table_mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            seq_len_reg   <= '0;
            pos_reg       <= '0;
            remaining_reg <= '0;
            enabled_reg   <= 1'b0;
            wrap_reg      <= '0;
            level_reg     <= '0;
            left_reg      <= '0;
            rd_addr_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        done_reg <= 1'b1;
                        unique case (cmd.mode)
                            MODE_LOAD:
                            begin
                                if (cmd.last_entry)
                                begin
                                    // Playback starts at slot zero with no time carried over.
                                    seq_len_reg <= {1'b0, cmd.tone_index} + 1'b1;
                                    pos_reg     <= '0;
                                    rd_addr_reg <= '0;
                                    left_reg    <= '0;
                                    done_reg    <= 1'b0;
                                    state_reg   <= ST_READ;
                                end
                            end
                            MODE_TICK:
                            begin
                                if (seq_len_reg != '0 && cmd.elapsed_ms != '0)
                                begin
                                    if (remaining_reg > cmd.elapsed_ms)
                                    begin
                                        remaining_reg <= remaining_reg - cmd.elapsed_ms;
                                    end
                                    else if (next_pos >= seq_len_reg)
                                    begin
                                        // The last tone has run out.
                                        enabled_reg   <= 1'b0;
                                        seq_len_reg   <= '0;
                                        pos_reg       <= '0;
                                        remaining_reg <= '0;
                                    end
                                    else
                                    begin
                                        pos_reg     <= next_pos[IDX_W-1:0];
                                        rd_addr_reg <= next_pos[IDX_W-1:0];
                                        left_reg    <= cmd.elapsed_ms - remaining_reg;
                                        done_reg    <= 1'b0;
                                        state_reg   <= ST_READ;
                                    end
                                end
                            end
                            MODE_STOP:
                            begin
                                enabled_reg   <= 1'b0;
                                seq_len_reg   <= '0;
                                pos_reg       <= '0;
                                remaining_reg <= '0;
                            end
                            default:
                            begin
                                // An unused mode only reports the state.
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_TONE;
                end
                ST_TONE:
                begin
                    // The time left over from the tick is taken off the new tone.
                    enabled_reg   <= 1'b1;
                    remaining_reg <= (left_reg >= tone_d) ? '0 : tone_d - left_reg;
                    if (tone_f == '0)
                    begin
                        // Silence keeps the wrap and drops the level.
                        level_reg <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        wrap_reg  <= wrap_next;
                        level_reg <= wrap_next[CLK_W-1:1];
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done                 = done_reg;
    assign res.output_enabled   = enabled_reg;
    assign res.period_wrap      = wrap_reg;
    assign res.duty_level       = level_reg;
    assign res.playing          = (seq_len_reg != '0);
    assign res.current_position = pos_reg;

    // The position always lies inside the sequence that is playing.
    a_pos_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg != '0) |-> ({1'b0, pos_reg} < seq_len_reg))
        else $error("position outside the sequence");

    // No result is reported while an item is still being worked on.
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe while busy");

    // Whenever a result is reported, the output is enabled exactly while playing.
    a_enable_play: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res.output_enabled == res.playing))
        else $error("output enable disagrees with playing");

    // A divider result arrives only while the player waits for it.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

endmodule

@@ tb/tone_sequence_player_tb.sv @@
// Self-checking testbench for the tone sequence player, with its own prediction of every result.
`timescale 1ns / 100ps

module tone_sequence_player_tb;
    import tsp_pkg::*;

    // The package has no name for the unused fourth mode, so it is named here.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    tsp_cmd_t         cmd;
    logic             done;
    tsp_res_t         res;
    logic             cfg_wr_en;
    logic [CLK_W-1:0] cfg_wr_data;

    tone_sequence_player u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .res         (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predicted player state. It starts out as the block does after reset.
    logic [ENTRY_W-1:0] tone_mem [TABLE_DEPTH];
    bit                 loaded [TABLE_DEPTH];
    logic [LEN_W-1:0]   seq_len    = '0;
    logic [IDX_W-1:0]   pos        = '0;
    logic [DUR_W-1:0]   remain     = '0;
    logic               tone_on    = 1'b0;
    logic [CLK_W-1:0]   wrap_val   = '0;
    logic [LEVEL_W-1:0] level_val  = '0;
    logic [CLK_W-1:0]   sys_freq_m = SYS_FREQ_RESET;

    // Results still owed by the block, oldest first.
    tsp_res_t expected_reports [$];

    int items_sent      = 0;
    int reports_checked = 0;
    int tones_started   = 0;
    int mismatches      = 0;
    int sender_idle_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Starting a tone enables the output. A silent tone only clears the level;
    // otherwise the frequency is clamped to half the clock (and to at least one)
    // before the wrap is worked out, and the level is half of the wrap.
    function automatic void begin_tone(input logic [ENTRY_W-1:0] entry);
        logic [CLK_W-1:0] f;
        logic [CLK_W-1:0] half;
        logic [CLK_W-1:0] q;
        tone_on = 1'b1;
        tones_started++;
        if (entry[FREQ_W-1:0] == '0)
        begin
            level_val = '0;
        end
        else
        begin
            half = sys_freq_m >> 1;
            f    = CLK_W'(entry[FREQ_W-1:0]);
            if (f > half)
                f = half;
            if (f == '0)
                f = CLK_W'(1);
            q         = sys_freq_m / f;
            wrap_val  = (q != '0) ? q - 1'b1 : '0;
            level_val = LEVEL_W'(wrap_val >> 1);
        end
    endfunction

    // Stopping keeps the wrap and the level but forgets the sequence.
    function automatic void silence_player();
        tone_on = 1'b0;
        seq_len = '0;
        pos     = '0;
        remain  = '0;
    endfunction

    // Works out the result of one accepted item and moves the predicted state on.
    function automatic tsp_res_t predict_player(input tsp_cmd_t c);
        tsp_res_t           r;
        logic [MS_W-1:0]    spill;
        logic [LEN_W-1:0]   nxt;
        logic [ENTRY_W-1:0] entry;
        case (c.mode)
            MODE_LOAD:
            begin
                tone_mem[c.tone_index] = {c.tone_duration, c.tone_freq};
                loaded[c.tone_index]   = 1'b1;
                if (c.last_entry)
                begin
                    seq_len = LEN_W'(c.tone_index) + 1'b1;
                    pos     = '0;
                    remain  = tone_mem[0][ENTRY_W-1:FREQ_W];
                    begin_tone(tone_mem[0]);
                end
            end
            MODE_TICK:
            begin
                if (seq_len != '0 && c.elapsed_ms != '0)
                begin
                    if (remain > c.elapsed_ms)
                    begin
                        remain = remain - c.elapsed_ms;
                    end
                    else
                    begin
                        // The tone has run out: move on by exactly one tone
                        // and take the leftover time off the new one.
                        spill = c.elapsed_ms - remain;
                        nxt   = LEN_W'(pos) + 1'b1;
                        if (nxt >= seq_len)
                        begin
                            silence_player();
                        end
                        else
                        begin
                            pos   = nxt[IDX_W-1:0];
                            entry = tone_mem[pos];
                            begin_tone(entry);
                            remain = (spill >= entry[ENTRY_W-1:FREQ_W]) ?
                                     '0 : entry[ENTRY_W-1:FREQ_W] - spill;
                        end
                    end
                end
            end
            MODE_STOP:
            begin
                silence_player();
            end
            default:
            begin
            end
        endcase
        r.output_enabled   = tone_on;
        r.period_wrap      = wrap_val;
        r.duty_level       = level_val;
        r.playing          = (seq_len != '0);
        r.current_position = pos;
        return r;
    endfunction

    // Number of slots loaded without a hole from slot 0 upwards. A final load
    // may only name a slot up to this one, so that no unloaded slot is played.
    function automatic int loaded_prefix();
        int n;
        n = 0;
        while (n < TABLE_DEPTH && loaded[n])
            n++;
        return n;
    endfunction

    // Fields that an item's mode does not use are filled at random, so that
    // the block is seen to ignore them.
    function automatic tsp_cmd_t random_cmd();
        tsp_cmd_t c;
        c.mode          = 2'($urandom_range(0, 3));
        c.tone_index    = IDX_W'($urandom);
        c.tone_freq     = FREQ_W'($urandom);
        c.tone_duration = DUR_W'($urandom);
        c.last_entry    = 1'($urandom);
        c.elapsed_ms    = MS_W'($urandom);
        return c;
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return FREQ_W'($urandom_range(1, 3));
            2:       return FREQ_W'($urandom);
            3:       return '1;
            default: return FREQ_W'($urandom_range(100, 8000));
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return DUR_W'($urandom);
            2:       return '1;
            default: return DUR_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [MS_W-1:0] pick_elapsed();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return MS_W'($urandom);
            2:       return '1;
            default: return MS_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Sends one item. Before it the sender may idle for a random number of
    // cycles. Afterwards start is left high, so that the next call can present
    // its item at once; whoever stops sending lowers it in the same step.
    task automatic send_item(input tsp_cmd_t item);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct)
                @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_reports.push_back(predict_player(item));
        items_sent++;
    endtask

    task automatic load_tone(input int idx, input logic [FREQ_W-1:0] freq,
                             input logic [DUR_W-1:0] dur, input bit last);
        tsp_cmd_t c;
        c               = random_cmd();
        c.mode          = MODE_LOAD;
        c.tone_index    = IDX_W'(idx);
        c.tone_freq     = freq;
        c.tone_duration = dur;
        c.last_entry    = last;
        send_item(c);
    endtask

    task automatic tick_ms(input logic [MS_W-1:0] ms);
        tsp_cmd_t c;
        c            = random_cmd();
        c.mode       = MODE_TICK;
        c.elapsed_ms = ms;
        send_item(c);
    endtask

    task automatic send_mode(input logic [1:0] m);
        tsp_cmd_t c;
        c      = random_cmd();
        c.mode = m;
        send_item(c);
    endtask

    // Holds the sender back until every owed result has arrived and the block
    // has gone idle. This is also the only point at which the clock register
    // is rewritten.
    task automatic wait_quiet();
        start <= 1'b0;
        while (expected_reports.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_sys_freq(input logic [CLK_W-1:0] hz);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hz;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        sys_freq_m  = hz;
    endtask

    // Random traffic. Most of it is a proper melody: slots 0 up to some length
    // are loaded, the last with its flag, and ticks then play it through, with
    // the odd stop, stray load or unused mode in between. The rest is noise of
    // any mode with random fields. Now and then the sender drains the block.
    task automatic play_random_melodies(input int item_goal);
        int len;
        int ticks;
        int r;
        int prefix;
        tsp_cmd_t c;
        while (items_sent < item_goal)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, TABLE_DEPTH)
                                                   : $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    load_tone(i, pick_freq(), pick_duration(), i == len - 1);
                ticks = 0;
                while (seq_len != '0 && ticks < 80)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        send_mode(MODE_STOP);
                    else if (r < 8)
                        load_tone($urandom_range(0, TABLE_DEPTH - 1), pick_freq(),
                                  pick_duration(), 1'b0);
                    else if (r < 10)
                        send_mode(MODE_SPARE);
                    else
                        tick_ms(pick_elapsed());
                    ticks++;
                end
                if (seq_len != '0)
                    send_mode(MODE_STOP);
            end
            else
            begin
                c      = random_cmd();
                prefix = loaded_prefix();
                if (c.mode == MODE_LOAD && c.last_entry && prefix < TABLE_DEPTH &&
                    c.tone_index > prefix)
                    c.tone_index = IDX_W'(prefix);
                send_item(c);
            end
            if ($urandom_range(0, 39) == 0)
                wait_quiet();
        end
        wait_quiet();
    endtask

    // Items that find the player idle: the unused mode with every field at its
    // top value, a tick with nothing playing and a stop with nothing playing.
    task automatic test_idle_items();
        tsp_cmd_t c;
        c      = '1;
        c.mode = MODE_SPARE;
        send_item(c);
        tick_ms('1);
        send_mode(MODE_STOP);
        wait_quiet();
    endtask

    // A short melody at the reset clock, stepped through by hand: a zero tick,
    // a countdown, a silent tone of zero length, a tone at the top frequency
    // and length, a load while playing into the top slot, the end of the
    // melody, a stop in the middle of a melody and a restart.
    task automatic test_directed_playback();
        load_tone(0, 16'd440, 16'd3, 1'b0);
        load_tone(1, 16'd0, 16'd0, 1'b0);
        load_tone(2, '1, '1, 1'b0);
        load_tone(3, 16'd1, 16'd2, 1'b1);
        tick_ms(16'd0);
        tick_ms(16'd1);
        tick_ms(16'd5);
        tick_ms(16'd1);
        load_tone(TABLE_DEPTH - 1, 16'd12345, 16'd7, 1'b0);
        tick_ms('1);
        tick_ms('1);
        load_tone(0, 16'd20000, 16'd10, 1'b1);
        send_mode(MODE_STOP);
        load_tone(2, 16'd0, 16'd5, 1'b1);
        tick_ms(16'd10);
        tick_ms(16'd3);
        tick_ms(16'd2);
        wait_quiet();
    endtask

    // Clocks so slow that half of them rounds to nothing, and one just above.
    task automatic test_tiny_clock();
        logic [CLK_W-1:0] tiny [3] = '{CLK_W'(0), CLK_W'(1), CLK_W'(3)};
        foreach (tiny[i])
        begin
            set_sys_freq(tiny[i]);
            load_tone(0, '1, 16'd1, 1'b1);
            tick_ms(16'd1);
            wait_quiet();
        end
    endtask

    // The lowest clock of the random runs, where most frequencies are clamped; the sender
    // idles about a quarter of the time.
    task automatic test_slow_clock_random();
        set_sys_freq(CLK_W'(1000));
        sender_idle_pct = 24;
        play_random_melodies(items_sent + 380);
    endtask

    // The highest clock the register holds, with the sender idling more often.
    task automatic test_fast_clock_random();
        set_sys_freq('1);
        sender_idle_pct = 56;
        play_random_melodies(items_sent + 380);
    endtask

    // Back-to-back items while the clock moves between random settings,
    // ending at the reset value again.
    task automatic test_changing_clock_random();
        sender_idle_pct = 0;
        for (int i = 0; i < 4; i++)
        begin
            set_sys_freq((i == 3) ? SYS_FREQ_RESET : CLK_W'($urandom_range(1000, 268435455)));
            play_random_melodies(items_sent + 100);
        end
    endtask

    // Every slot loaded, the top one with the flag, and the whole table
    // played through to its end.
    task automatic test_full_table();
        int ticks;
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_tone(i, pick_freq(), DUR_W'($urandom_range(0, 3)), i == TABLE_DEPTH - 1);
        ticks = 0;
        while (seq_len != '0 && ticks < 400)
        begin
            tick_ms(MS_W'($urandom_range(1, 4)));
            ticks++;
        end
        wait_quiet();
    endtask

    // Each result is taken at the edge that ends its strobe cycle and checked
    // against the oldest owed result.
    always @(posedge clk)
    begin : check_reports
        tsp_res_t want;
        if (rst_n && done)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result arrived with none owed");
                mismatches++;
            end
            else
            begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (res.output_enabled !== want.output_enabled)
                begin
                    $error("output_enabled: expected %0d, got %0d",
                           want.output_enabled, res.output_enabled);
                    mismatches++;
                end
                if (res.period_wrap !== want.period_wrap)
                begin
                    $error("period_wrap: expected %0d, got %0d",
                           want.period_wrap, res.period_wrap);
                    mismatches++;
                end
                if (res.duty_level !== want.duty_level)
                begin
                    $error("duty_level: expected %0d, got %0d",
                           want.duty_level, res.duty_level);
                    mismatches++;
                end
                if (res.playing !== want.playing)
                begin
                    $error("playing: expected %0d, got %0d", want.playing, res.playing);
                    mismatches++;
                end
                if (res.current_position !== want.current_position)
                begin
                    $error("current_position: expected %0d, got %0d",
                           want.current_position, res.current_position);
                    mismatches++;
                end
            end
        end
    end

    // A run that hangs is ended here, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_items();
        test_directed_playback();
        test_tiny_clock();
        test_slow_clock_random();
        test_fast_clock_random();
        test_changing_clock_random();
        test_full_table();

        wait_quiet();
        repeat (40) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            $error("%0d results never arrived", expected_reports.size());
            mismatches++;
        end
        $display("summary: %0d items sent, %0d results checked, %0d tone starts predicted",
                 items_sent, reports_checked, tones_started);
        $display("summary: clocks from 0 Hz to the register maximum, sender idling 24%%, 56%% and 0%%");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
